### design/tile_background_pixel_render_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tile background renderer.
// Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef TILE_BACKGROUND_PIXEL_RENDER_CORE_ASSERT_SVH
`define TILE_BACKGROUND_PIXEL_RENDER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition in one cycle implies the consequence in the next cycle
`define TBPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbpr: assertion failed");

// Condition implies the consequence in the same cycle
`define TBPR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbpr: assertion failed");

`else

`define TBPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define TBPR_ASSERT_SAME(lbl, clk, rst, ante, cons)

`endif

`endif

### design/tbpr_pkg.sv
// ---------------------------------------------------------------------------
// tbpr_pkg
// Types, constants and helpers shared by the tile background renderer.
// ---------------------------------------------------------------------------
package tbpr_pkg;

   localparam int VRAM_BYTES   = 8192;
   localparam int VRAM_ADDR_W  = 13;

   // Map region is the top 2 KiB; tile data is the low 6 KiB, held as
   // 16-bit byte pairs with the even byte in the lower lane.
   localparam int MAP_DEPTH    = 2048;
   localparam int MAP_ADDR_W   = 11;
   localparam int PAIR_DEPTH   = 3072;
   localparam int PAIR_ADDR_W  = 12;

   localparam logic [PAIR_ADDR_W-1:0] SIGNED_PAIR_BASE = 12'h400;
   localparam logic [7:0] LAST_LINE   = 8'd143;
   localparam logic [7:0] WIN_X_SHIFT = 8'd7;

   // lcd_control bit positions
   localparam int LCD_BG_ON      = 0;
   localparam int LCD_BG_MAP     = 3;
   localparam int LCD_TILE_UNSGN = 4;
   localparam int LCD_WIN_ON     = 5;
   localparam int LCD_WIN_MAP    = 6;

   localparam logic [15:0] COLOR_SHADE0 = 16'hFFFF;
   localparam logic [15:0] COLOR_SHADE1 = 16'h00EF;
   localparam logic [15:0] COLOR_SHADE2 = 16'h00E0;
   localparam logic [15:0] COLOR_SHADE3 = 16'h0000;

   typedef enum logic [2:0] {
      CSR_LCD_CONTROL = 3'd0,
      CSR_SCROLL_Y    = 3'd1,
      CSR_SCROLL_X    = 3'd2,
      CSR_WINDOW_Y    = 3'd3,
      CSR_WINDOW_X    = 3'd4,
      CSR_BG_PALETTE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] lcd_control;
      logic [7:0] scroll_y;
      logic [7:0] scroll_x;
      logic [7:0] window_y;
      logic [7:0] window_x;
      logic [7:0] bg_palette;
   } cfg_type;

   function automatic logic [15:0] shade_color(input logic [1:0] shade);
      logic [15:0] color;
      unique case (shade)
         2'd0:    color = COLOR_SHADE0;
         2'd1:    color = COLOR_SHADE1;
         2'd2:    color = COLOR_SHADE2;
         default: color = COLOR_SHADE3;
      endcase
      return color;
   endfunction

endpackage

### design/tbpr_ram.sv
// ---------------------------------------------------------------------------
// tbpr_ram
// Generic single-write, single-read synchronous RAM with registered read
// and a bit write mask.
// A read and write of the same entry on one edge returns the old data.
// ---------------------------------------------------------------------------
module tbpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_mask,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= (mem_ff[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tbpr_vram.sv
// ---------------------------------------------------------------------------
// tbpr_vram
// Video memory split into a map memory and a tile data memory of byte pairs,
// so that one map read and one tile row (two bytes) read can issue every
// cycle.
// ---------------------------------------------------------------------------
module tbpr_vram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [tbpr_pkg::VRAM_ADDR_W-1:0]  wr_addr,
   input  logic [7:0]                        wr_data,
   input  logic [tbpr_pkg::MAP_ADDR_W-1:0]   map_addr,
   input  logic [tbpr_pkg::PAIR_ADDR_W-1:0]  pair_addr,
   output logic [7:0]                        map_data,
   output logic [7:0]                        lo_data,
   output logic [7:0]                        hi_data
);
   import tbpr_pkg::*;

   logic        in_map;
   logic        map_we;
   logic        pair_we;
   logic [15:0] pair_mask;
   logic [15:0] pair_data;

   // Top quarter of the address space is the tile map
   assign in_map    = (wr_addr[VRAM_ADDR_W-1:VRAM_ADDR_W-2] == 2'b11);
   assign map_we    = wr_en && in_map;
   assign pair_we   = wr_en && !in_map;
   // odd bytes take the upper lane of a pair
   assign pair_mask = wr_addr[0] ? 16'hFF00 : 16'h00FF;

   tbpr_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_mask (8'hFF),
      .wr_addr (wr_addr[MAP_ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (map_addr),
      .rd_data (map_data)
   );

   tbpr_ram #(.WIDTH(16), .DEPTH(PAIR_DEPTH)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_we),
      .wr_mask (pair_mask),
      .wr_addr (wr_addr[VRAM_ADDR_W-1:1]),
      .wr_data ({wr_data, wr_data}),
      .rd_addr (pair_addr),
      .rd_data (pair_data)
   );

   assign lo_data = pair_data[7:0];
   assign hi_data = pair_data[15:8];

endmodule

### design/tbpr_csr.sv
// ---------------------------------------------------------------------------
// tbpr_csr
// Configuration register file; unknown indexes are dropped.
// ---------------------------------------------------------------------------
module tbpr_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  tbpr_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_data,
   output tbpr_pkg::cfg_type       cfg
);
   import tbpr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_go;

   assign csr_ready = !reset;
   assign wr_go     = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_go) begin
         unique case (csr_index)
            CSR_LCD_CONTROL: cfg_in.lcd_control = csr_data;
            CSR_SCROLL_Y:    cfg_in.scroll_y    = csr_data;
            CSR_SCROLL_X:    cfg_in.scroll_x    = csr_data;
            CSR_WINDOW_Y:    cfg_in.window_y    = csr_data;
            CSR_WINDOW_X:    cfg_in.window_x    = csr_data;
            CSR_BG_PALETTE:  cfg_in.bg_palette  = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lcd_control <= 8'd145;
         cfg_ff.scroll_y    <= 8'd0;
         cfg_ff.scroll_x    <= 8'd0;
         cfg_ff.window_y    <= 8'd0;
         cfg_ff.window_x    <= 8'd0;
         cfg_ff.bg_palette  <= 8'd252;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/tile_background_pixel_render_core.sv
// ---------------------------------------------------------------------------
// tile_background_pixel_render_core
// Tile map background and window pixel renderer with 8 KiB video memory.
// ---------------------------------------------------------------------------
// A new item is taken every clock cycle; busy is high only during reset.
// Write items store one byte and give no result. Each render item gives one
// result on rsp_valid, in order, after passing the s1, s2 and result
// registers; the receiver cannot stall, so results must be taken as they
// appear. The result path holds two dependent video memory reads, the tile
// map lookup and then the tile row fetch, each a registered RAM read,
// followed by a registered palette stage. No clearing pass runs after reset:
// video memory holds nothing defined until written.
// ---------------------------------------------------------------------------
`include "tile_background_pixel_render_core_assert.svh"

module tile_background_pixel_render_core #(
   parameter int LINE_PIXELS = 160
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic [12:0]             req_vram_addr,
   input  logic [7:0]              req_vram_data,
   input  logic [7:0]              req_pixel_x,
   input  logic [7:0]              req_line_y,
   output logic                    rsp_valid,
   output logic [15:0]             rsp_pixel_color,
   output logic                    rsp_drawn,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  tbpr_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_data
);
   import tbpr_pkg::*;

   cfg_type cfg;

   logic accept_go;
   logic render_go;
   logic write_go;

   // stage 0: map lookup address
   logic [7:0]            win_start;
   logic                  in_window;
   logic [7:0]            xp;
   logic [7:0]            yp;
   logic                  map_sel;
   logic [MAP_ADDR_W-1:0] map_addr;
   logic                  off_screen;

   // stage 1: tile row address
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_off_ff;
   logic [2:0] s1_row_ff;
   logic [2:0] s1_col_ff;
   logic [7:0] map_data;
   logic [PAIR_ADDR_W-1:0] pair_addr;

   // stage 2: pixel value and shade
   logic       s2_valid_ff, s2_valid_in;
   logic       s2_off_ff;
   logic [2:0] s2_col_ff;
   logic [7:0] lo_data;
   logic [7:0] hi_data;
   logic [2:0] bit_sel;
   logic [1:0] pix_value;
   logic [1:0] shade;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_color_ff, rsp_color_in;
   logic        rsp_drawn_ff, rsp_drawn_in;

   assign busy      = reset;
   assign accept_go = start && !busy;
   assign render_go = accept_go && req_action;
   assign write_go  = accept_go && !req_action;

   tbpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   always_comb begin
      win_start = cfg.window_x - WIN_X_SHIFT;
      in_window = cfg.lcd_control[LCD_WIN_ON] && (cfg.window_y <= req_line_y)
                  && (req_pixel_x >= win_start);
      if (in_window) begin
         map_sel = cfg.lcd_control[LCD_WIN_MAP];
         yp      = req_line_y - cfg.window_y;
         xp      = req_pixel_x - win_start;
      end else begin
         map_sel = cfg.lcd_control[LCD_BG_MAP];
         yp      = req_line_y + cfg.scroll_y;
         xp      = req_pixel_x + cfg.scroll_x;
      end
      map_addr   = {map_sel, yp[7:3], xp[7:3]};
      off_screen = !cfg.lcd_control[LCD_BG_ON]
                   || ({1'b0, req_pixel_x} >= 9'(LINE_PIXELS))
                   || (req_line_y > LAST_LINE);
   end

   // Signed mode: tile number biased by 0x80 from the 0x8800 base
   always_comb begin
      if (cfg.lcd_control[LCD_TILE_UNSGN]) begin
         pair_addr = {1'b0, map_data, s1_row_ff};
      end else begin
         pair_addr = SIGNED_PAIR_BASE + {1'b0, map_data ^ 8'h80, s1_row_ff};
      end
   end

   tbpr_vram u_vram (
      .clock     (clock),
      .wr_en     (write_go),
      .wr_addr   (req_vram_addr),
      .wr_data   (req_vram_data),
      .map_addr  (map_addr),
      .pair_addr (pair_addr),
      .map_data  (map_data),
      .lo_data   (lo_data),
      .hi_data   (hi_data)
   );

   always_comb begin
      bit_sel      = 3'd7 - s2_col_ff;
      pix_value    = {hi_data[bit_sel], lo_data[bit_sel]};
      shade        = cfg.bg_palette[{pix_value, 1'b0} +: 2];
      s1_valid_in  = render_go;
      s2_valid_in  = s1_valid_ff;
      rsp_valid_in = s2_valid_ff;
      rsp_drawn_in = !s2_off_ff;
      rsp_color_in = s2_off_ff ? 16'h0000 : shade_color(shade);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_off_ff    <= off_screen;
      s1_row_ff    <= yp[2:0];
      s1_col_ff    <= xp[2:0];
      s2_off_ff    <= s1_off_ff;
      s2_col_ff    <= s1_col_ff;
      rsp_color_ff <= rsp_color_in;
      rsp_drawn_ff <= rsp_drawn_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_drawn       = rsp_drawn_ff;

   `TBPR_ASSERT_NEXT(a_render_enters, clock, reset, render_go, s1_valid_ff)
   `TBPR_ASSERT_NEXT(a_write_no_result, clock, reset, write_go, !s1_valid_ff)
   `TBPR_ASSERT_NEXT(a_stage_advance, clock, reset, s1_valid_ff, s2_valid_ff)
   `TBPR_ASSERT_NEXT(a_result_follows, clock, reset, s2_valid_ff, rsp_valid)
   `TBPR_ASSERT_SAME(a_hidden_black, clock, reset, rsp_valid && !rsp_drawn,
                     rsp_pixel_color == 16'h0000)

endmodule
